// ===== sv/mlv_pkg.sv =====
// mlv_pkg: shared constants, types, exponent table and fixed-point helpers
// for the ladder lowpass filter. No dependencies.
package mlv_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int STATE_W   = 24;
  localparam int FRAC      = STATE_W - 4;
  localparam int DW        = 32;                 // ladder datapath width
  localparam int EXP_DEPTH = 256;
  localparam int EXP_AW    = $clog2(EXP_DEPTH);
  localparam int REM_W     = 31 - EXP_AW;
  localparam int SR_W      = 18;
  localparam int NUM_W     = 57;                 // 38-bit scaled mantissa, up to 19 octaves up
  localparam int HI_W      = NUM_W - 31;
  localparam int RES_KNOB_SH = FRAC - 15;
  localparam int RES_CV_SH   = SAMPLE_W + 14 - FRAC;
  localparam int IN_SH       = FRAC - (SAMPLE_W - 1);

  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam logic signed [20:0] LOG2_1000_Q16 = 21'sd653118;
  localparam logic [5:0] TWICE_BASE_HZ = 6'd40;

  localparam logic signed [DW-1:0] ONE     = DW'(64'sd1 <<< FRAC);
  localparam logic signed [DW-1:0] K_08    = DW'(((64'sd1 <<< FRAC) * 4) / 5);
  localparam logic signed [DW-1:0] K_56    = DW'(((64'sd1 <<< FRAC) * 28) / 5);
  localparam logic signed [DW-1:0] K_SIXTH = DW'(((64'sd1 <<< FRAC) + 3) / 6);

  typedef enum logic [2:0] {
    REG_CUTOFF_KNOB    = 3'd0,
    REG_RESONANCE_KNOB = 3'd1,
    REG_CUTOFF_GAIN    = 3'd2,
    REG_RESONANCE_GAIN = 3'd3,
    REG_SAMPLE_RATE    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]     cutoff_knob;
    logic [15:0]     resonance_knob;
    logic [15:0]     cutoff_cv_gain;
    logic [15:0]     resonance_cv_gain;
    logic [SR_W-1:0] sample_rate_hz;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [STATE_W-1:0]  fn;
    logic signed [STATE_W-1:0]  res;
  } job_t;

  typedef enum logic [3:0] {
    FS_IDLE, FS_EXP, FS_RES, FS_LOG, FS_INTERP, FS_SCALE, FS_CHECK, FS_DIV, FS_PUSH
  } front_state_e;

  typedef enum logic [4:0] {
    LS_IDLE, LS_C0, LS_C1, LS_C2, LS_C3, LS_C4, LS_C5, LS_C6,
    LS_F0, LS_F1, LS_F2, LS_F3, LS_F4, LS_F5, LS_F6, LS_F7, LS_F8,
    LS_S0, LS_S1, LS_S2, LS_S3
  } ladder_state_e;

  typedef logic [31:0] exp_tab_t [EXP_DEPTH+1];

  // series term divided by its index, fixed divisors only
  function automatic longint unsigned div_by_index(longint unsigned v, int i);
    case (i)
      2:       return v >> 1;
      3:       return v / 3;
      4:       return v >> 2;
      5:       return v / 5;
      6:       return v / 6;
      7:       return v / 7;
      8:       return v >> 3;
      9:       return v / 9;
      10:      return v / 10;
      11:      return v / 11;
      12:      return v / 12;
      13:      return v / 13;
      14:      return v / 14;
      default: return v;
    endcase
  endfunction

  // 2^(k/D) in Q30 from a truncated exponential series
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      x    = (longint'(k) * LN2_Q30) >> EXP_AW;
      term = 64'd1 << 30;
      sum  = term;
      for (int i = 1; i <= 14; i++) begin
        term = div_by_index((term * x) >> 30, i);
        sum  = sum + term;
      end
      tab[k] = sum[31:0];
    end
    tab[EXP_DEPTH] = 32'h8000_0000;
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  function automatic logic signed [DW-1:0] mulq(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] pr;
    pr = a * b;
    return DW'(pr >>> FRAC);
  endfunction

  function automatic logic signed [DW-1:0] sat_state(logic signed [DW-1:0] v);
    logic signed [DW-1:0] lim;
    lim = DW'(64'sd1 <<< (STATE_W - 1));
    if (v < -lim) return -lim;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  function automatic logic signed [DW-1:0] ext_st(logic signed [STATE_W-1:0] v);
    return {{(DW-STATE_W){v[STATE_W-1]}}, v};
  endfunction

endpackage

// ===== sv/mlv_front.sv =====
// mlv_front: accepts samples, forms cutoff fn (exponent table, iterative
// divide by sample rate) and resonance, and hands a job to the queue. Uses mlv_pkg.
module mlv_front import mlv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] audio_in_i,
  input  logic signed [SAMPLE_W-1:0] cutoff_cv_i,
  input  logic signed [SAMPLE_W-1:0] resonance_cv_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output job_t                       job_o
);

  localparam logic signed [25:0]      ONE26   = 26'(ONE);
  localparam logic signed [STATE_W-1:0] ONE_ST = STATE_W'(ONE);

  front_state_e state_q, state_d;
  logic signed [SAMPLE_W-1:0] x_q, x_d, cc_q, cc_d, rc_q, rc_d;
  logic signed [17:0]         e_q, e_d;
  logic signed [STATE_W-1:0]  res_q, res_d;
  logic signed [7:0]          n_q, n_d;
  logic [30:0]                frac_q, frac_d;
  logic [31:0]                mant_q, mant_d;
  logic [NUM_W-1:0]           num_q, num_d;
  logic                       sat_q, sat_d;
  logic [SR_W-1:0]            rem_q, rem_d;
  logic [30:0]                quo_q, quo_d;
  logic [4:0]                 cnt_q, cnt_d;

  logic signed [32:0]         cmul;
  logic signed [25:0]         rsum;
  logic signed [38:0]         y_c;
  logic [EXP_AW-1:0]          idx;
  logic [31:0]                tlo, thi, diff;
  logic [31+REM_W:0]          dprod;
  logic [37:0]                num0;
  logic [SR_W-1:0]            sr_c;
  logic [HI_W-1:0]            hi;
  logic [SR_W:0]              trial;
  logic signed [STATE_W-1:0]  fn_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    cc_q   <= cc_d;
    rc_q   <= rc_d;
    e_q    <= e_d;
    res_q  <= res_d;
    n_q    <= n_d;
    frac_q <= frac_d;
    mant_q <= mant_d;
    num_q  <= num_d;
    sat_q  <= sat_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  assign sr_c = (cfg_i.sample_rate_hz == '0) ? SR_W'(1) : cfg_i.sample_rate_hz;

  always_comb begin
    state_d = state_q;
    x_d = x_q; cc_d = cc_q; rc_d = rc_q;
    e_d = e_q; res_d = res_q; n_d = n_q; frac_d = frac_q;
    mant_d = mant_q; num_d = num_q; sat_d = sat_q;
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;

    cmul  = '0;
    rsum  = '0;
    y_c   = '0;
    idx   = frac_q[30 -: EXP_AW];
    tlo   = EXP_TAB[idx];
    thi   = EXP_TAB[{1'b0, idx} + 1'b1];
    diff  = thi - tlo;
    dprod = diff * frac_q[REM_W-1:0];
    num0  = 38'(mant_q) * TWICE_BASE_HZ;
    hi    = num_q[NUM_W-1:31];
    trial = {rem_q, num_q[30]};

    if (sat_q || (quo_q > 31'(32'h4000_0000))) begin
      fn_c = ONE_ST;
    end else begin
      fn_c = STATE_W'(quo_q >> (30 - FRAC));
    end

    unique case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d = audio_in_i;
          cc_d = cutoff_cv_i;
          rc_d = resonance_cv_i;
          state_d = FS_EXP;
        end
      end
      FS_EXP: begin
        cmul = cc_q * $signed({1'b0, cfg_i.cutoff_cv_gain});
        e_d = $signed({2'b00, cfg_i.cutoff_knob}) + 18'(cmul >>> SAMPLE_W);
        state_d = FS_RES;
      end
      FS_RES: begin
        cmul = rc_q * $signed({1'b0, cfg_i.resonance_cv_gain});
        rsum = $signed(26'(cfg_i.resonance_knob) << RES_KNOB_SH) + 26'(cmul >>> RES_CV_SH);
        if (rsum > ONE26) begin
          res_d = ONE_ST;
        end else if (rsum < -ONE26) begin
          res_d = -ONE_ST;
        end else begin
          res_d = STATE_W'(rsum);
        end
        state_d = FS_LOG;
      end
      FS_LOG: begin
        y_c = e_q * LOG2_1000_Q16;
        n_d = 8'(y_c >>> 31);
        frac_d = y_c[30:0];
        state_d = FS_INTERP;
      end
      FS_INTERP: begin
        mant_d = tlo + 32'(dprod >> REM_W);
        state_d = FS_SCALE;
      end
      FS_SCALE: begin
        sat_d = (n_q >= 8'sd20);
        if (n_q >= 8'sd0) begin
          num_d = NUM_W'(num0) << n_q[4:0];
        end else begin
          num_d = NUM_W'(num0) >> 8'(-n_q);
        end
        state_d = FS_CHECK;
      end
      FS_CHECK: begin
        // integer part of the quotient already at or above 2^31: clips to 1.0
        if (sat_q || (hi >= HI_W'(sr_c))) begin
          sat_d = 1'b1;
          state_d = FS_PUSH;
        end else begin
          rem_d = SR_W'(hi);
          quo_d = '0;
          cnt_d = 5'd30;
          state_d = FS_DIV;
        end
      end
      FS_DIV: begin
        if (trial >= {1'b0, sr_c}) begin
          rem_d = SR_W'(trial - {1'b0, sr_c});
          quo_d = {quo_q[29:0], 1'b1};
        end else begin
          rem_d = SR_W'(trial);
          quo_d = {quo_q[29:0], 1'b0};
        end
        num_d = num_q << 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  assign job_o.x   = x_q;
  assign job_o.fn  = fn_c;
  assign job_o.res = res_q;

endmodule

// ===== sv/mlv_queue.sv =====
// mlv_queue: two-entry job queue between the cutoff front and the ladder.
// Uses mlv_pkg for the job type.
module mlv_queue import mlv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/mlv_ladder.sv =====
// mlv_ladder: coefficient calculation, four-pole ladder and soft clip on one
// shared registered multiplier, with an output register. Uses mlv_pkg.
module mlv_ladder import mlv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  output logic                       job_ready_o,
  input  job_t                       job_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] audio_out_o
);

  localparam logic signed [DW-1:0] OUT_MAX = DW'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [DW-1:0] OUT_MIN = -DW'(64'sd1 <<< (SAMPLE_W - 1));

  ladder_state_e state_q, state_d;
  job_t                      job_q, job_d;
  logic signed [DW-1:0]      mq_q, ma, mb;
  logic                      mul_en;
  logic signed [DW-1:0]      q0_q, q0_d, p_q, p_d, f_q, f_d;
  logic signed [DW-1:0]      xin_q, xin_d, tmp_q, tmp_d, b4_q, b4_d;
  logic signed [STATE_W-1:0] n1_q, n1_d, n2_q, n2_d, n3_q, n3_d;
  logic signed [STATE_W-1:0] s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  logic signed [STATE_W-1:0] prev_q, prev_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_q, out_d;

  logic signed [DW-1:0] fn_c, res_c, xin0, fin, oclip, oshift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LS_IDLE;
      out_valid_q <= 1'b0;
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0; prev_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d; s4_q <= s4_d; prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (mul_en) mq_q <= mulq(ma, mb);
    q0_q <= q0_d; p_q <= p_d; f_q <= f_d;
    xin_q <= xin_d; tmp_q <= tmp_d; b4_q <= b4_d;
    n1_q <= n1_d; n2_q <= n2_d; n3_q <= n3_d;
    out_q <= out_d;
  end

  assign fn_c  = ext_st(job_q.fn);
  assign res_c = ext_st(job_q.res);
  assign xin0  = DW'($signed(job_q.x)) <<< IN_SH;
  assign fin   = sat_state(b4_q - mq_q);

  always_comb begin
    if (fin > ONE) begin
      oclip = ONE;
    end else if (fin < -ONE) begin
      oclip = -ONE;
    end else begin
      oclip = fin;
    end
    oshift = oclip >>> IN_SH;
  end

  always_comb begin
    state_d = state_q;
    job_d = job_q;
    q0_d = q0_q; p_d = p_q; f_d = f_q;
    xin_d = xin_q; tmp_d = tmp_q; b4_d = b4_q;
    n1_d = n1_q; n2_d = n2_q; n3_d = n3_q;
    s1_d = s1_q; s2_d = s2_q; s3_d = s3_q; s4_d = s4_q; prev_d = prev_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ma = '0;
    mb = '0;
    mul_en = 1'b1;
    job_ready_o = 1'b0;

    unique case (state_q)
      LS_IDLE: begin
        mul_en = 1'b0;
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          job_d = job_i;
          state_d = LS_C0;
        end
      end
      LS_C0: begin
        q0_d = ONE - fn_c;
        ma = K_08; mb = fn_c;
        state_d = LS_C1;
      end
      LS_C1: begin
        ma = mq_q; mb = q0_q;
        state_d = LS_C2;
      end
      LS_C2: begin
        p_d = fn_c + mq_q;
        f_d = ((fn_c + mq_q) <<< 1) - ONE;
        ma = q0_q; mb = q0_q;
        state_d = LS_C3;
      end
      LS_C3: begin
        ma = K_56; mb = mq_q;
        state_d = LS_C4;
      end
      LS_C4: begin
        ma = q0_q; mb = ONE - q0_q + mq_q;
        state_d = LS_C5;
      end
      LS_C5: begin
        ma = res_c; mb = ONE + (mq_q >>> 1);
        state_d = LS_C6;
      end
      LS_C6: begin
        // feedback q * stage four
        ma = mq_q; mb = ext_st(s4_q);
        state_d = LS_F0;
      end
      LS_F0: begin
        if (xin0 > ONE) begin
          xin_d = sat_state(ONE - mq_q);
        end else if (xin0 < -ONE) begin
          xin_d = sat_state(-ONE - mq_q);
        end else begin
          xin_d = sat_state(xin0 - mq_q);
        end
        ma = ext_st(s1_q); mb = f_q;
        state_d = LS_F1;
      end
      LS_F1: begin
        tmp_d = mq_q;
        ma = xin_q + ext_st(prev_q); mb = p_q;
        state_d = LS_F2;
      end
      LS_F2: begin
        n1_d = STATE_W'(sat_state(mq_q - tmp_q));
        ma = ext_st(s2_q); mb = f_q;
        state_d = LS_F3;
      end
      LS_F3: begin
        tmp_d = mq_q;
        ma = ext_st(n1_q) + ext_st(s1_q); mb = p_q;
        state_d = LS_F4;
      end
      LS_F4: begin
        n2_d = STATE_W'(sat_state(mq_q - tmp_q));
        ma = ext_st(s3_q); mb = f_q;
        state_d = LS_F5;
      end
      LS_F5: begin
        tmp_d = mq_q;
        ma = ext_st(n2_q) + ext_st(s2_q); mb = p_q;
        state_d = LS_F6;
      end
      LS_F6: begin
        n3_d = STATE_W'(sat_state(mq_q - tmp_q));
        ma = ext_st(s4_q); mb = f_q;
        state_d = LS_F7;
      end
      LS_F7: begin
        tmp_d = mq_q;
        ma = ext_st(n3_q) + ext_st(s3_q); mb = p_q;
        state_d = LS_F8;
      end
      LS_F8: begin
        mul_en = 1'b0;
        b4_d = sat_state(mq_q - tmp_q);
        state_d = LS_S0;
      end
      LS_S0: begin
        ma = b4_q; mb = b4_q;
        state_d = LS_S1;
      end
      LS_S1: begin
        tmp_d = mq_q;
        ma = b4_q; mb = K_SIXTH;
        state_d = LS_S2;
      end
      LS_S2: begin
        ma = tmp_q; mb = mq_q;
        state_d = LS_S3;
      end
      LS_S3: begin
        // hold here until the output register frees up
        mul_en = 1'b0;
        if (!out_valid_q || out_ready_i) begin
          s1_d = n1_q;
          s2_d = n2_q;
          s3_d = n3_q;
          s4_d = STATE_W'(fin);
          prev_d = STATE_W'(xin_q);
          if (oshift > OUT_MAX) begin
            out_d = SAMPLE_W'(OUT_MAX);
          end else if (oshift < OUT_MIN) begin
            out_d = SAMPLE_W'(OUT_MIN);
          end else begin
            out_d = SAMPLE_W'(oshift);
          end
          out_valid_d = 1'b1;
          state_d = LS_IDLE;
        end
      end
      default: state_d = LS_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign audio_out_o = out_q;

endmodule

// ===== sv/moog_ladder_lowpass_vcf_core.sv =====
// moog_ladder_lowpass_vcf_core: top level with APB register file, cutoff
// front end, job queue and ladder back end. Uses mlv_pkg, mlv_front, mlv_queue, mlv_ladder.
//
//   channel   signals                                      direction
//   input     in_valid_i/in_ready_o, audio_in_i,           in
//             cutoff_cv_i, resonance_cv_i
//   output    out_valid_o/out_ready_i, audio_out_o         out
//   config    psel, penable, pwrite, paddr, pwdata,        APB slave
//             prdata, pready
//
// The front takes one sample at a time and runs a radix-2 divide by the
// sample rate unless the cutoff saturates; the ladder works each job on its
// one shared multiplier while the front, decoupled by the queue, takes the
// next sample. Reset zeroes the filter state with no sweep; a stalled output
// holds the ladder at its last step while the front fills the queue until it is full.
module moog_ladder_lowpass_vcf_core import mlv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] audio_in_i,
  input  logic signed [SAMPLE_W-1:0] cutoff_cv_i,
  input  logic signed [SAMPLE_W-1:0] resonance_cv_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] audio_out_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  job_t     fq_data, qb_data;
  logic     fq_valid, fq_ready, qb_valid, qb_ready;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff_knob       <= '0;
      cfg_q.resonance_knob    <= '0;
      cfg_q.cutoff_cv_gain    <= '0;
      cfg_q.resonance_cv_gain <= '0;
      cfg_q.sample_rate_hz    <= SR_W'(44100);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CUTOFF_KNOB:    cfg_q.cutoff_knob       <= pwdata[15:0];
        REG_RESONANCE_KNOB: cfg_q.resonance_knob    <= pwdata[15:0];
        REG_CUTOFF_GAIN:    cfg_q.cutoff_cv_gain    <= pwdata[15:0];
        REG_RESONANCE_GAIN: cfg_q.resonance_cv_gain <= pwdata[15:0];
        REG_SAMPLE_RATE:    cfg_q.sample_rate_hz    <= pwdata[SR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CUTOFF_KNOB:    prdata = 32'(cfg_q.cutoff_knob);
      REG_RESONANCE_KNOB: prdata = 32'(cfg_q.resonance_knob);
      REG_CUTOFF_GAIN:    prdata = 32'(cfg_q.cutoff_cv_gain);
      REG_RESONANCE_GAIN: prdata = 32'(cfg_q.resonance_cv_gain);
      REG_SAMPLE_RATE:    prdata = 32'(cfg_q.sample_rate_hz);
      default:            prdata = '0;
    endcase
  end

  mlv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .audio_in_i     (audio_in_i),
    .cutoff_cv_i    (cutoff_cv_i),
    .resonance_cv_i (resonance_cv_i),
    .job_valid_o    (fq_valid),
    .job_ready_i    (fq_ready),
    .job_o          (fq_data)
  );

  mlv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_data)
  );

  mlv_ladder u_ladder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .audio_out_o (audio_out_o)
  );

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for moog_ladder_lowpass_vcf_core.
// Uses mlv_pkg for the register indexes; the filter predictor is built in.
`timescale 1ns / 100ps

class ladder_scoreboard;
  longint          knob_cut, knob_res, gain_cut, gain_res, rate_hz;
  longint          s_prev, s1, s2, s3, s4;
  longint unsigned pow2_tab [257];
  logic [15:0]     expected_q [$];
  int              mismatches;

  function new();
    longint unsigned x, term, sum;
    for (int k = 0; k < 256; k++) begin
      x    = (longint'(k) * 64'd744261118) / 256;
      term = 64'd1 << 30;
      sum  = term;
      for (int i = 1; i <= 14; i++) begin
        term = ((term * x) >> 30) / i;
        sum  = sum + term;
      end
      pow2_tab[k] = sum;
    end
    pow2_tab[256] = 64'd1 << 31;
    knob_cut = 0; knob_res = 0; gain_cut = 0; gain_res = 0; rate_hz = 44100;
    s_prev = 0; s1 = 0; s2 = 0; s3 = 0; s4 = 0;
    mismatches = 0;
  endfunction

  function void set_reg(mlv_pkg::reg_idx_e idx, longint v);
    case (idx)
      mlv_pkg::REG_CUTOFF_KNOB:    knob_cut = v & 16'hFFFF;
      mlv_pkg::REG_RESONANCE_KNOB: knob_res = v & 16'hFFFF;
      mlv_pkg::REG_CUTOFF_GAIN:    gain_cut = v & 16'hFFFF;
      mlv_pkg::REG_RESONANCE_GAIN: gain_res = v & 16'hFFFF;
      mlv_pkg::REG_SAMPLE_RATE:    rate_hz  = v & 18'h3FFFF;
      default: ;
    endcase
  endfunction

  function longint fx_mul(longint a, longint b);
    return (a * b) >>> 20;
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint sat24(longint v);
    return clip(v, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
  endfunction

  // one sample through cutoff mapping, coefficients, the four stages and soft clip
  function void note_input(logic signed [15:0] x, logic signed [15:0] cc,
                           logic signed [15:0] rc);
    longint          one, e, y, n, frac, fn, res, q0, p, f, q, inner, t, xin, b4, o1, o2, o3;
    longint          outv;
    longint unsigned prod, idx, rem, mant, num, fn30, sr;
    one  = 64'sd1 <<< 20;
    e    = knob_cut + ((longint'(cc) * gain_cut) >>> 16);
    y    = e * 653118;
    n    = y >>> 31;
    frac = y - (n <<< 31);
    prod = longint'(frac) * 256;
    idx  = prod >> 31;
    rem  = prod & 64'h7FFF_FFFF;
    mant = pow2_tab[idx] + (((pow2_tab[idx+1] - pow2_tab[idx]) * rem) >> 31);
    sr   = (rate_hz == 0) ? 1 : rate_hz;
    num  = 40 * mant;
    if (n >= 20) begin
      fn30 = 64'd1 << 30;
    end else begin
      if (n >= 0) num = num << n;
      else num = (-n > 63) ? 0 : (num >> (-n));
      fn30 = num / sr;
      if (fn30 > (64'd1 << 30)) fn30 = 64'd1 << 30;
    end
    fn  = longint'(fn30 >> 10);
    res = clip(knob_res * 32 + ((longint'(rc) * gain_res) >>> 10), -one, one);
    q0    = one - fn;
    p     = fn + fx_mul(fx_mul((one * 4) / 5, fn), q0);
    f     = p + p - one;
    inner = one - q0 + fx_mul((one * 28) / 5, fx_mul(q0, q0));
    t     = fx_mul(q0, inner) >>> 1;
    q     = fx_mul(res, one + t);
    xin = clip(longint'(x) * 32, -one, one);
    xin = sat24(xin - fx_mul(q, s4));
    o1 = s1; o2 = s2; o3 = s3;
    s1 = sat24(fx_mul(xin + s_prev, p) - fx_mul(o1, f));
    s2 = sat24(fx_mul(s1 + o1, p) - fx_mul(o2, f));
    s3 = sat24(fx_mul(s2 + o2, p) - fx_mul(o3, f));
    b4 = sat24(fx_mul(s3 + o3, p) - fx_mul(s4, f));
    b4 = sat24(b4 - fx_mul(fx_mul(b4, b4), fx_mul(b4, (one + 3) / 6)));
    s4 = b4;
    s_prev = xin;
    outv = clip(clip(b4, -one, one) >>> 5, -32768, 32767);
    expected_q.push_back(outv[15:0]);
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output item %0d", $signed(got));
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("audio_out mismatch: expected %0d got %0d", $signed(want), $signed(got));
    end
  endfunction
endclass

module tb;
  import mlv_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic signed [15:0] audio_in_i = '0, cutoff_cv_i = '0, resonance_cv_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] audio_out_o;

  ladder_scoreboard sb;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  int  idle_cycles = 0;
  int  items_sent = 0;

  moog_ladder_lowpass_vcf_core DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random stall per item, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(audio_out_o);
        rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 600;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready_i <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout: no progress");
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(int'(idx) * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_all(int ck, int rk, int cg, int rg, int sr);
    reg_write(REG_CUTOFF_KNOB, ck);
    reg_write(REG_RESONANCE_KNOB, rk);
    reg_write(REG_CUTOFF_GAIN, cg);
    reg_write(REG_RESONANCE_GAIN, rg);
    reg_write(REG_SAMPLE_RATE, sr);
  endtask

  task automatic send_item(logic signed [15:0] a, logic signed [15:0] c,
                           logic signed [15:0] r, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    audio_in_i <= a; cutoff_cv_i <= c; resonance_cv_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(a, c, r);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 30000)) - 15000);
    endcase
  endfunction

  task automatic random_phase(int count, bit no_gap);
    for (int i = 0; i < count; i++)
      send_item(rand_sample(), rand_sample(), rand_sample(), no_gap);
    drain();
  endtask

  initial begin
    logic signed [15:0] ext [4];
    sb = new();
    ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: defaults, then full-scale corners with knobs and gains at 32768
    send_item(16'sh7FFF, 0, 0, 0);
    send_item(16'sh8000, 0, 0, 0);
    send_item(0, 0, 0, 0);
    drain();
    set_all(32768, 32768, 32768, 32768, 192000);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 3)
        send_item(ext[i], ext[j], ext[3-j], 0);
    drain();
    // zero sample rate and register values beyond the nominal range
    set_all(65535, 65535, 65535, 65535, 0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
    send_item(16'sh8000, 16'sh7FFF, 16'sh8000, 0);
    send_item(16'sh1234, 16'sh0000, 16'shFFFF, 0);
    drain();
    set_all(0, 0, 0, 0, 8000);
    send_item(16'sh7FFF, 16'sh8000, 16'sh8000, 0);
    send_item(16'sh4000, 16'sh7FFF, 16'sh7FFF, 0);
    drain();
    set_all(0, 0, 0, 0, 18'h3FFFF);
    send_item(16'sh7FFF, 16'sh7FFF, 0, 0);
    send_item(16'sh8000, 16'sh8000, 0, 0);
    drain();

    // long receiver hold-off while the sender keeps going back to back
    set_all(20000, 24000, 8000, 8000, 44100);
    hold_req = 1;
    random_phase(60, 1);

    for (int ph = 0; ph < 8; ph++) begin
      set_all($urandom_range(0, 32768), $urandom_range(0, 32768),
              $urandom_range(0, 32768), $urandom_range(0, 32768),
              $urandom_range(8000, 192000));
      random_phase(100, ph == 3);
    end
    set_all(32768, 32768, 32768, 32768, 8000);
    random_phase(40, 0);

    $display("sent %0d items over 15 register settings incl. corner rates", items_sent);
    $display("covered full-scale inputs, back-to-back traffic and output backpressure");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
